[design/ckd_pkg.sv]
package ckd_pkg;

    // Sample format and arithmetic widths.
    localparam int SAMPLE_BITS = 16;
    localparam int PROD_BITS   = 2 * SAMPLE_BITS;
    localparam int SUM_BITS    = 48;
    localparam int POS_BITS    = 10;
    localparam int MOD_BITS    = 2;
    localparam int CFG_INDEX_BITS = 2;

    // Modulation codes.
    localparam logic [MOD_BITS-1:0] MOD_ASK = 2'd0;
    localparam logic [MOD_BITS-1:0] MOD_PSK = 2'd1;
    localparam logic [MOD_BITS-1:0] MOD_FSK = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MODULATION = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESHOLD  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW     = 2'd2;

    // Register values after reset.
    localparam logic [MOD_BITS-1:0] MODULATION_RESET    = MOD_ASK;
    localparam logic [SUM_BITS-1:0] THRESHOLD_RESET     = 48'd26844;
    localparam logic [POS_BITS-1:0] WINDOW_LENGTH_RESET = 10'd20;

    // One input beat.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] received_sample;
        logic signed [SAMPLE_BITS-1:0] reference_a;
        logic signed [SAMPLE_BITS-1:0] reference_b;
        logic                          end_of_stream;
    } ckd_in_t;

    // One result beat.
    typedef struct packed {
        logic decided_bit;
        logic final_result;
    } ckd_out_t;

    // A configuration write as seen by the datapath.
    typedef struct packed {
        logic                      valid;
        logic [CFG_INDEX_BITS-1:0] index;
        logic [SUM_BITS-1:0]       data;
    } ckd_cfg_wr_t;

    // Results produced by one item, packed from slot zero upward.
    typedef struct packed {
        logic [1:0] count;
        ckd_out_t   slot0;
        ckd_out_t   slot1;
    } ckd_push_t;

endpackage

[design/ckd_front.sv]
module ckd_front
    import ckd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ckd_cfg_wr_t cfg_wr,
    input  logic        take,
    input  ckd_in_t     item,
    output ckd_push_t   push
);

    // Configuration registers.
    logic [MOD_BITS-1:0] modulation_reg;
    logic [SUM_BITS-1:0] threshold_reg;
    logic [POS_BITS-1:0] window_length_reg;

    // Multiply stage.
    logic                        s1_valid_reg;
    logic                        s1_eos_reg;
    logic signed [PROD_BITS-1:0] prod_a_reg;
    logic signed [PROD_BITS-1:0] prod_b_reg;
    logic signed [PROD_BITS-1:0] prod_a_next;
    logic signed [PROD_BITS-1:0] prod_b_next;

    // Integrator stage.
    logic [POS_BITS-1:0] pos_reg;
    logic [POS_BITS-1:0] pos_next;
    logic [SUM_BITS-1:0] sum_a_reg;
    logic [SUM_BITS-1:0] sum_a_next;
    logic [SUM_BITS-1:0] sum_b_reg;
    logic [SUM_BITS-1:0] sum_b_next;
    logic                s2_valid_reg;
    logic                s2_eos_reg;

    // Decision stage.
    logic                prev_above_reg;
    logic                prev_above_next;
    logic                have_prev_reg;
    logic                have_prev_next;

    logic [SUM_BITS-1:0]        base_a;
    logic [SUM_BITS-1:0]        base_b;
    logic [SUM_BITS-1:0]        acc_a;
    logic signed [PROD_BITS-1:0] prod_a_clamped;
    logic [POS_BITS-1:0]        window_len;
    logic [POS_BITS-1:0]        pos_inc;
    logic signed [SUM_BITS:0]   value;
    logic signed [SUM_BITS:0]   threshold_ext;
    logic                       above;

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulation_reg    <= MODULATION_RESET;
            threshold_reg     <= THRESHOLD_RESET;
            window_length_reg <= WINDOW_LENGTH_RESET;
        end
        else if (cfg_wr.valid)
        begin
            case (cfg_wr.index)
                CFG_MODULATION: modulation_reg    <= cfg_wr.data[MOD_BITS-1:0];
                CFG_THRESHOLD:  threshold_reg     <= cfg_wr.data;
                CFG_WINDOW:     window_length_reg <= cfg_wr.data[POS_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // Products of the received sample with both references.
    assign prod_a_next = PROD_BITS'(item.received_sample) * PROD_BITS'(item.reference_a);
    assign prod_b_next = PROD_BITS'(item.received_sample) * PROD_BITS'(item.reference_b);

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
            s1_eos_reg <= item.end_of_stream;
        end
    end

    // The integrators restart whenever the window position is zero.
    always_comb
    begin
        base_a         = (pos_reg == '0) ? '0 : sum_a_reg;
        base_b         = (pos_reg == '0) ? '0 : sum_b_reg;
        prod_a_clamped = prod_a_reg[PROD_BITS-1] ? '0 : prod_a_reg;
        sum_b_next     = base_b + SUM_BITS'(prod_b_reg);
        case (modulation_reg)
            MOD_ASK:
            begin
                acc_a      = base_a + SUM_BITS'(prod_a_clamped);
                sum_a_next = acc_a[SUM_BITS-1] ? '0 : acc_a;
            end
            default:
            begin
                acc_a      = base_a + SUM_BITS'(prod_a_reg);
                sum_a_next = acc_a;
            end
        endcase
        window_len = (window_length_reg == '0) ? POS_BITS'(1) : window_length_reg;
        pos_inc    = pos_reg + POS_BITS'(1);
        if (s1_eos_reg || (pos_inc >= window_len))
        begin
            pos_next = '0;
        end
        else
        begin
            pos_next = pos_inc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            sum_a_reg  <= sum_a_next;
            sum_b_reg  <= sum_b_next;
            s2_eos_reg <= s1_eos_reg;
        end
    end

    // Detector value against the threshold, then the one-late decision.
    always_comb
    begin
        threshold_ext = {threshold_reg[SUM_BITS-1], threshold_reg};
        case (modulation_reg)
            MOD_FSK: value = {sum_b_reg[SUM_BITS-1], sum_b_reg}
                           - {sum_a_reg[SUM_BITS-1], sum_a_reg};
            default: value = {sum_a_reg[SUM_BITS-1], sum_a_reg};
        endcase
        above = value > threshold_ext;

        push.count      = 2'd0;
        push.slot0      = '0;
        push.slot1      = '0;
        prev_above_next = prev_above_reg;
        have_prev_next  = have_prev_reg;
        if (s2_valid_reg)
        begin
            if (have_prev_reg)
            begin
                push.slot0.decided_bit  = prev_above_reg | above;
                push.slot0.final_result = 1'b0;
                push.count              = 2'd1;
            end
            if (s2_eos_reg)
            begin
                if (have_prev_reg)
                begin
                    push.slot1.decided_bit  = above;
                    push.slot1.final_result = 1'b1;
                    push.count              = 2'd2;
                end
                else
                begin
                    push.slot0.decided_bit  = above;
                    push.slot0.final_result = 1'b1;
                    push.count              = 2'd1;
                end
                prev_above_next = 1'b0;
                have_prev_next  = 1'b0;
            end
            else
            begin
                prev_above_next = above;
                have_prev_next  = 1'b1;
            end
        end
    end

    // Control state of the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            pos_reg        <= '0;
            prev_above_reg <= 1'b0;
            have_prev_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= take;
            s2_valid_reg   <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                pos_reg <= pos_next;
            end
            prev_above_reg <= prev_above_next;
            have_prev_reg  <= have_prev_next;
        end
    end

endmodule

[design/ckd_queue.sv]
module ckd_queue
    import ckd_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  ckd_push_t push,
    input  logic      pop,
    output logic      head_valid,
    output ckd_out_t  head,
    output logic      space_ok
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    // Three items can be in flight (two pipeline stages plus the one being
    // taken), each giving up to two results.
    localparam int RESERVE  = 6;

    ckd_out_t            mem_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_next;
    logic [PTR_BITS-1:0] wr_ptr_second;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;

    function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
        logic [PTR_BITS-1:0] r;
        if (p == PTR_BITS'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_BITS'(1);
        end
        return r;
    endfunction

    // Pointer and fill count bookkeeping.
    always_comb
    begin
        wr_ptr_second = ptr_inc(wr_ptr_reg);
        case (push.count)
            2'd0:    wr_ptr_next = wr_ptr_reg;
            2'd1:    wr_ptr_next = wr_ptr_second;
            default: wr_ptr_next = ptr_inc(wr_ptr_second);
        endcase
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_BITS'(push.count) - CNT_BITS'(pop);
    end

    // Result storage; slot one is written only with slot zero.
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.slot0;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_second] <= push.slot1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Output side comes straight from stored entries.
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign space_ok   = (count_reg <= CNT_BITS'(DEPTH - RESERVE));

    // The fill count never passes the depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(DEPTH))
        else $error("result queue count exceeds its depth");

    // A push never lands on entries that are still occupied.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, count_reg} + (CNT_BITS + 1)'(push.count) - (CNT_BITS + 1)'(pop))
            <= (CNT_BITS + 1)'(DEPTH))
        else $error("result queue overflow");

    // An empty queue that receives nothing stays empty.
    a_empty_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 && push.count == 2'd0) |=> !head_valid)
        else $error("result appeared without a push");

endmodule

[design/coherent_keying_demodulator_top.sv]
// Coherent keying demodulator with integrate-and-dump detection.
// Sample channel: sample_valid / sample_stall carry one received sample and
// two reference carrier samples (signed Q1.14) plus an end-of-stream mark.
// Decision channel: decision_valid / decision_stall carry one decided bit per
// beat, with final_result set on the decision of the stream's last sample.
// Configuration: cfg_valid / cfg_ready, always ready; index 0 modulation,
// 1 threshold, 2 window length. Write only while the block is idle.
// Throughput: one sample per cycle while sample_stall is low. The multiply
// and accumulate stages are registered and the decide stage is combinational,
// so a decision enters the result queue from the accumulate registers and is
// offered once the queue holds it. Each sample's decision waits for the
// following sample; an end-of-stream sample releases its own beat and any
// beat still waiting. The sample channel stalls when the result queue lacks
// room for the results of every sample still in flight.
// Reset returns the registers to their defaults and empties the pipeline,
// the integrators and the queue. A stalled decision beat holds its value.
module coherent_keying_demodulator_top
    import ckd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      sample_valid,
    output logic                      sample_stall,
    input  ckd_in_t                   sample,
    output logic                      decision_valid,
    input  logic                      decision_stall,
    output ckd_out_t                  decision,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [SUM_BITS-1:0]       cfg_wdata
);

    ckd_cfg_wr_t cfg_wr;
    ckd_push_t   push;
    logic        take;
    logic        pop;
    logic        space_ok;

    // Configuration writes are always taken.
    assign cfg_ready    = 1'b1;
    assign cfg_wr.valid = cfg_valid;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_wdata;

    // Handshakes on both channels.
    assign sample_stall = !space_ok;
    assign take         = sample_valid && space_ok;
    assign pop          = decision_valid && !decision_stall;

    ckd_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_wr (cfg_wr),
        .take   (take),
        .item   (sample),
        .push   (push)
    );

    ckd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (pop),
        .head_valid (decision_valid),
        .head       (decision),
        .space_ok   (space_ok)
    );

endmodule

[sim/coherent_keying_demodulator_top_tb.sv]
`timescale 1ns / 1ps

module coherent_keying_demodulator_top_tb
    import ckd_pkg::*;
();

    // Run length and timing figures.
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int HOLD_CYCLES   = 150;
    localparam int PHASES        = 8;
    localparam int PHASE_SAMPLES = 50;

    // Selector code that the package leaves unnamed; it acts as phase keying.
    localparam logic [MOD_BITS-1:0] MOD_UNUSED = 2'd3;

    // Decision beats that the directed rows spell out by hand.
    localparam ckd_out_t BIT0_MID  = '{decided_bit: 1'b0, final_result: 1'b0};
    localparam ckd_out_t BIT1_MID  = '{decided_bit: 1'b1, final_result: 1'b0};
    localparam ckd_out_t BIT0_LAST = '{decided_bit: 1'b0, final_result: 1'b1};
    localparam ckd_out_t BIT1_LAST = '{decided_bit: 1'b1, final_result: 1'b1};

    // Sample extremes.
    localparam logic [SAMPLE_BITS-1:0] S_MAX = 16'h7fff;
    localparam logic [SAMPLE_BITS-1:0] S_MIN = 16'h8000;

    typedef enum logic { ROW_CONFIG, ROW_SAMPLE } row_kind_t;

    // One row of the directed part: a register write or a sample beat.
    // A sample row with typed_count of -1 is checked against the predictor.
    typedef struct packed {
        row_kind_t                 kind;
        logic [CFG_INDEX_BITS-1:0] reg_index;
        logic [SUM_BITS-1:0]       reg_value;
        ckd_in_t                   beat;
        int                        typed_count;
        ckd_out_t                  typed_first;
        ckd_out_t                  typed_second;
    } stim_row_t;

    logic                      clk            = 1'b0;
    logic                      rst_n          = 1'b0;
    logic                      sample_valid   = 1'b0;
    logic                      sample_stall;
    ckd_in_t                   sample         = '0;
    logic                      decision_valid;
    logic                      decision_stall = 1'b0;
    ckd_out_t                  decision;
    logic                      cfg_valid      = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index      = '0;
    logic [SUM_BITS-1:0]       cfg_wdata      = '0;

    // Mirror of the block's registers and integrator state.
    logic [MOD_BITS-1:0]        mod_sel;
    logic signed [SUM_BITS-1:0] thresh;
    logic [POS_BITS-1:0]        win_len;
    logic [POS_BITS-1:0]        win_pos;
    logic signed [SUM_BITS-1:0] integ_a;
    logic signed [SUM_BITS-1:0] integ_b;
    logic                       prev_above;
    logic                       decision_pending;

    // Decisions still owed by the block, oldest first.
    ckd_out_t  owed_decisions[$];
    stim_row_t directed_rows[$];

    int fail_count       = 0;
    int decisions_seen   = 0;
    int samples_sent     = 0;
    int streams_closed   = 0;
    int settings_written = 0;
    int cycle_count      = 0;
    int send_idle_pct    = 0;
    int stall_pct        = 0;
    int hold_req         = 0;
    int hold_ack         = 0;
    int hold_left        = 0;

    coherent_keying_demodulator_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .sample_stall   (sample_stall),
        .sample         (sample),
        .decision_valid (decision_valid),
        .decision_stall (decision_stall),
        .decision       (decision),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    // 4 ns clock.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Abort the run if the block stops making progress.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d decisions owed",
                     cycle_count, owed_decisions.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Decision side stall: random, or one long hold-off when requested.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            decision_stall <= 1'b1;
            hold_left      <= hold_left - 1;
        end
        else if (hold_req != hold_ack)
        begin
            decision_stall <= 1'b1;
            hold_left      <= HOLD_CYCLES;
            hold_ack       <= hold_req;
        end
        else
        begin
            decision_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Compare each accepted decision beat with the oldest owed decision.
    always @(posedge clk)
    begin : check_decisions
        ckd_out_t want;
        if (rst_n && decision_valid && !decision_stall)
        begin
            decisions_seen++;
            if (owed_decisions.size() == 0)
            begin
                $error("Decision beat %b arrived with none owed", decision);
                fail_count++;
            end
            else
            begin
                want = owed_decisions.pop_front();
                if (decision.decided_bit !== want.decided_bit)
                begin
                    $error("decided_bit: expected %b, got %b",
                           want.decided_bit, decision.decided_bit);
                    fail_count++;
                end
                if (decision.final_result !== want.final_result)
                begin
                    $error("final_result: expected %b, got %b",
                           want.final_result, decision.final_result);
                    fail_count++;
                end
            end
        end
    end

    // Integrate one sample and decide; returns how many decisions it frees.
    function automatic int decide_sample(input ckd_in_t beat,
                                         output ckd_out_t first,
                                         output ckd_out_t second);
        logic signed [PROD_BITS-1:0] prod_a;
        logic signed [PROD_BITS-1:0] prod_b;
        logic signed [SUM_BITS-1:0]  step_a;
        logic signed [SUM_BITS:0]    level;
        logic [POS_BITS-1:0]         span;
        logic                        over;
        int                          count;
        count  = 0;
        first  = BIT0_MID;
        second = BIT0_MID;
        prod_a = beat.received_sample * beat.reference_a;
        prod_b = beat.received_sample * beat.reference_b;
        span   = (win_len == '0) ? POS_BITS'(1) : win_len;

        // A window opens: dump both integrators.
        if (win_pos == '0)
        begin
            integ_a = '0;
            integ_b = '0;
        end

        // Amplitude keying clips negative products and a negative sum.
        step_a = prod_a;
        if (mod_sel == MOD_ASK)
        begin
            if (step_a < 0)
                step_a = '0;
            integ_a = integ_a + step_a;
            if (integ_a < 0)
                integ_a = '0;
        end
        else
        begin
            integ_a = integ_a + step_a;
        end
        integ_b = integ_b + SUM_BITS'(prod_b);

        win_pos = win_pos + 1'b1;
        if (win_pos >= span)
            win_pos = '0;

        // Frequency keying compares the difference of the two integrators.
        if (mod_sel == MOD_FSK)
            level = {integ_b[SUM_BITS-1], integ_b} - {integ_a[SUM_BITS-1], integ_a};
        else
            level = integ_a;
        over = level > thresh;

        if (decision_pending)
        begin
            first = '{decided_bit: prev_above | over, final_result: 1'b0};
            count = 1;
        end

        // The last sample flushes its own decision and restarts the stream.
        if (beat.end_of_stream)
        begin
            if (count == 0)
                first = '{decided_bit: over, final_result: 1'b1};
            else
                second = '{decided_bit: over, final_result: 1'b1};
            count++;
            decision_pending = 1'b0;
            prev_above       = 1'b0;
            win_pos          = '0;
            integ_a          = '0;
            integ_b          = '0;
        end
        else
        begin
            prev_above       = over;
            decision_pending = 1'b1;
        end
        return count;
    endfunction

    // Offer one sample beat, wait for it to be taken, then record what it owes.
    task automatic push_sample(input ckd_in_t beat, input int typed_count,
                               input ckd_out_t typed_first, input ckd_out_t typed_second);
        ckd_out_t first;
        ckd_out_t second;
        int       count;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= beat;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        samples_sent++;
        if (beat.end_of_stream)
            streams_closed++;
        count = decide_sample(beat, first, second);
        if (typed_count >= 0)
        begin
            count  = typed_count;
            first  = typed_first;
            second = typed_second;
        end
        if (count > 0)
            owed_decisions = {owed_decisions, first};
        if (count > 1)
            owed_decisions = {owed_decisions, second};
    endtask

    // Register write once the block has gone quiet.
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [SUM_BITS-1:0] value);
        sample_valid <= 1'b0;
        while (owed_decisions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        settings_written++;
        case (idx)
            CFG_MODULATION: mod_sel = value[MOD_BITS-1:0];
            CFG_THRESHOLD:  thresh  = value;
            CFG_WINDOW:     win_len = value[POS_BITS-1:0];
            default:        ;
        endcase
    endtask

    function automatic void add_cfg(input logic [CFG_INDEX_BITS-1:0] idx,
                                    input logic [SUM_BITS-1:0] value);
        stim_row_t row;
        row           = '0;
        row.kind      = ROW_CONFIG;
        row.reg_index = idx;
        row.reg_value = value;
        directed_rows = {directed_rows, row};
    endfunction

    function automatic void add_item(input logic [SAMPLE_BITS-1:0] rx,
                                     input logic [SAMPLE_BITS-1:0] ra,
                                     input logic [SAMPLE_BITS-1:0] rb,
                                     input logic eos, input int count,
                                     input ckd_out_t first, input ckd_out_t second);
        stim_row_t row;
        row                      = '0;
        row.kind                 = ROW_SAMPLE;
        row.beat.received_sample = rx;
        row.beat.reference_a     = ra;
        row.beat.reference_b     = rb;
        row.beat.end_of_stream   = eos;
        row.typed_count          = count;
        row.typed_first          = first;
        row.typed_second         = second;
        directed_rows            = {directed_rows, row};
    endfunction

    initial
    begin : stimulus
        ckd_in_t              beat;
        logic [31:0]          r32;
        logic [SUM_BITS-1:0]  thr_value;
        logic [POS_BITS-1:0]  len_value;
        int                   pick;

        mod_sel          = MODULATION_RESET;
        thresh           = THRESHOLD_RESET;
        win_len          = WINDOW_LENGTH_RESET;
        win_pos          = '0;
        integ_a          = '0;
        integ_b          = '0;
        prev_above       = 1'b0;
        decision_pending = 1'b0;

        // Amplitude keying after reset: largest products, clipping, one-late decisions.
        add_item(S_MAX, S_MAX, 16'h0000, 1'b1, 1, BIT1_LAST, BIT0_MID);
        add_item(S_MIN, S_MAX, S_MIN, 1'b1, 1, BIT0_LAST, BIT0_MID);
        add_item(16'h0000, 16'h0000, 16'h0000, 1'b0, 0, BIT0_MID, BIT0_MID);
        add_item(S_MIN, S_MIN, S_MIN, 1'b0, 1, BIT1_MID, BIT0_MID);
        add_item(S_MAX, S_MIN, S_MAX, 1'b1, 2, BIT1_MID, BIT1_LAST);
        // Phase keying keeps negative sums.
        add_cfg(CFG_MODULATION, SUM_BITS'(MOD_PSK));
        add_item(S_MIN, S_MAX, 16'h0000, 1'b0, 0, BIT0_MID, BIT0_MID);
        add_item(S_MIN, S_MAX, 16'h0000, 1'b1, 2, BIT0_MID, BIT0_LAST);
        // Frequency keying against both threshold extremes.
        add_cfg(CFG_MODULATION, SUM_BITS'(MOD_FSK));
        add_cfg(CFG_THRESHOLD, 48'h7fff_ffff_ffff);
        add_item(S_MAX, S_MIN, S_MAX, 1'b1, 1, BIT0_LAST, BIT0_MID);
        add_cfg(CFG_THRESHOLD, 48'h8000_0000_0000);
        add_item(16'h0000, 16'h0000, 16'h0000, 1'b1, 1, BIT1_LAST, BIT0_MID);
        // Unused selector code, longest window, then the window cut short mid-way.
        add_cfg(CFG_MODULATION, SUM_BITS'(MOD_UNUSED));
        add_cfg(CFG_THRESHOLD, '0);
        add_cfg(CFG_WINDOW, 48'd1023);
        add_item(16'd100, 16'd100, 16'hff9c, 1'b0, -1, BIT0_MID, BIT0_MID);
        add_item(16'hffff, 16'h0001, 16'h0001, 1'b0, -1, BIT0_MID, BIT0_MID);
        add_item(S_MAX, S_MIN, 16'h0001, 1'b0, -1, BIT0_MID, BIT0_MID);
        add_cfg(CFG_WINDOW, 48'd2);
        add_item(16'h4000, 16'hc000, 16'h4000, 1'b0, -1, BIT0_MID, BIT0_MID);
        add_item(16'h1234, 16'h5678, 16'h9abc, 1'b0, -1, BIT0_MID, BIT0_MID);
        // A zero window length acts as one sample per window.
        add_cfg(CFG_WINDOW, '0);
        add_item(16'h2000, 16'h2000, 16'he000, 1'b0, -1, BIT0_MID, BIT0_MID);
        add_item(16'he000, 16'h2000, 16'h2000, 1'b1, -1, BIT0_MID, BIT0_MID);
        // Amplitude keying with a mix of signs over one-sample windows.
        add_cfg(CFG_MODULATION, SUM_BITS'(MOD_ASK));
        add_cfg(CFG_WINDOW, 48'd1);
        add_item(16'd1000, 16'hfc18, 16'd1000, 1'b0, -1, BIT0_MID, BIT0_MID);
        add_item(16'd5, 16'd5, 16'd5, 1'b1, -1, BIT0_MID, BIT0_MID);

        // Hold reset low before releasing it.
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed rows.
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CONFIG)
                write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
            else
                push_sample(directed_rows[i].beat, directed_rows[i].typed_count,
                            directed_rows[i].typed_first, directed_rows[i].typed_second);
        end

        // Random phases: new settings each time, idling pattern changes as we go.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase < 3)
            begin
                send_idle_pct = 35;
                stall_pct    <= 82;
            end
            else if (phase < 6)
            begin
                send_idle_pct = 82;
                stall_pct    <= 35;
            end
            else
            begin
                send_idle_pct = 0;
                stall_pct    <= 0;
            end

            // Threshold mostly near the integrator's working range, rarely an extreme.
            r32       = $urandom;
            thr_value = {{16{r32[31]}}, r32} << $urandom_range(0, 6);
            pick      = $urandom_range(0, 9);
            if (pick == 0)
                thr_value = 48'h7fff_ffff_ffff;
            else if (pick == 1)
                thr_value = 48'h8000_0000_0000;

            // Window mostly short, with the edge lengths now and then.
            pick = $urandom_range(0, 9);
            if (pick == 0)
                len_value = '0;
            else if (pick == 1)
                len_value = 10'd1023;
            else
                len_value = POS_BITS'($urandom_range(1, 40));

            write_reg(CFG_MODULATION, SUM_BITS'($urandom_range(0, 3)));
            write_reg(CFG_THRESHOLD, thr_value);
            write_reg(CFG_WINDOW, SUM_BITS'(len_value));

            // Last phase: hold the decision side off so the block backs up.
            if (phase == PHASES - 1)
                hold_req <= hold_req + 1;

            for (int n = 0; n < PHASE_SAMPLES; n++)
            begin
                beat.reference_a = SAMPLE_BITS'($urandom);
                beat.reference_b = SAMPLE_BITS'($urandom);
                pick = $urandom_range(0, 3);
                case (pick)
                    0:       beat.received_sample = SAMPLE_BITS'($urandom);
                    1:       beat.received_sample = beat.reference_a;
                    2:       beat.received_sample = beat.reference_b;
                    default: beat.received_sample = -beat.reference_a;
                endcase
                if ($urandom_range(0, 15) == 0)
                    beat.received_sample = $urandom_range(0, 1) ? S_MAX : S_MIN;
                if ($urandom_range(0, 15) == 0)
                    beat.reference_a = $urandom_range(0, 1) ? S_MAX : S_MIN;
                beat.end_of_stream = ($urandom_range(0, 9) == 0);
                push_sample(beat, -1, BIT0_MID, BIT0_MID);
            end
        end

        // Let the block drain, then give it its latency once more.
        sample_valid <= 1'b0;
        while (owed_decisions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d samples in %0d closed streams over %0d register writes.",
                 samples_sent, streams_closed, settings_written);
        $display("Checked %0d decisions under three idling patterns and one long hold-off.",
                 decisions_seen);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
